### design/bnce_pkg.sv
package bnce_pkg;

  localparam int unsigned ACC_W  = 64;
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned IN_DW  = 104;
  localparam int unsigned OUT_DW = 88;

  localparam logic [1:0] REG_TRAIN = 2'd0;
  localparam logic [1:0] REG_EPS   = 2'd1;
  localparam logic [1:0] REG_MOM   = 2'd2;

  localparam logic [16:0] MOM_ONE   = 17'd65536;
  localparam logic [23:0] INV_SAT   = 24'hFFFFFF;
  localparam logic        KIND_ELEM  = 1'b0;
  localparam logic        KIND_STATS = 1'b1;

  typedef enum logic [1:0] {
    FN_PARAM = 2'd0,
    FN_MEAN  = 2'd1,
    FN_VAR   = 2'd2,
    FN_NORM  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    WR_SWEEP = 2'd0,
    WR_PARAM = 2'd1,
    WR_MEAN  = 2'd2,
    WR_STATS = 2'd3
  } wr_sel_e;

  typedef enum logic [2:0] {
    AR_DIV_MEAN  = 3'd0,
    AR_DIV_VAR   = 3'd1,
    AR_INV_SWEEP = 3'd2,
    AR_INV_PARAM = 3'd3,
    AR_INV_BATCH = 3'd4,
    AR_INV_RUN   = 3'd5
  } ar_op_e;

  typedef enum logic [2:0] {
    MUL_NONE  = 3'd0,
    MUL_DEV   = 3'd1,
    MUL_NORM  = 3'd2,
    MUL_SCALE = 3'd3,
    MUL_MB    = 3'd4,
    MUL_MR    = 3'd5,
    MUL_VB    = 3'd6,
    MUL_VR    = 3'd7
  } mul_op_e;

  // one channel row of the parameter and statistics store
  typedef struct packed {
    logic signed [15:0] scale;
    logic signed [15:0] shift;
    logic signed [31:0] rmean;
    logic        [31:0] rvar;
    logic signed [31:0] bmean;
    logic        [23:0] binv;
    logic        [23:0] rinv;
  } row_t;

  localparam row_t ROW_RESET = '{scale: 16'sd256, shift: 16'sd0, rmean: 32'sd0,
                                 rvar: 32'd0, bmean: 32'sd0, binv: 24'd0,
                                 rinv: 24'd0};

  typedef struct packed {
    logic    latch_item;
    logic    ram_rd;
    logic    ram_wr;
    logic    use_sweep;
    logic    sweep_init;
    logic    sweep_clr;
    logic    sweep_inc;
    wr_sel_e wr_sel;
    logic    arith_start;
    ar_op_e  arith_op;
    mul_op_e mul_op;
    logic    mac_load;
    logic    rmean_fin;
    logic    rvar_fin;
    logic    bv_fin;
    logic    binv_fin;
    logic    normed_fin;
    logic    scaled_fin;
    logic    acc_step;
    logic    acc_clr;
    logic    emit;
    logic    emit_kind;
  } cmd_t;

  typedef struct packed {
    func_e in_func;
    logic  in_ch_ok;
    func_e item_func;
    logic  item_last;
    logic  train;
    logic  eps_wr;
    logic  arith_done;
    logic  sweep_last;
    logic  out_free;
  } stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
    logic signed [15:0] r;
    if (v > 66'sd32767) r = 16'sh7FFF;
    else if (v < -66'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

### design/batch_norm_channel_engine_unit.sv
// a mean/variance element is dispatched and accumulated; a normalize is multiplied, rounded,
// scaled and loaded into the output register; a close divides the sum by the element count;
// one request at a time, none accepted until the last is done; the 64-step divider and the
// 25-step square root dominate parameter writes and batch closes
// reset: config regs return to defaults, then a sweep rebuilds the running inverse std of
// every channel; an epsilon write repeats that sweep, none accepted then
module batch_norm_channel_engine_unit
  import bnce_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 64,
  parameter int unsigned MAX_ELEMENTS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request side
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // channel, sample, gamma_in, beta_in, mean_in, var_in, zero pad
  input  logic [IN_DW-1:0]  s_axis_tdata,
  // func
  input  logic [1:0]        s_axis_tuser,
  input  logic              s_axis_tlast,
  // result side
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // out_channel, scaled_out, normed_out, batch_mean_out, batch_var_out, zero pad
  output logic [OUT_DW-1:0] m_axis_tdata,
  // kind
  output logic              m_axis_tuser,
  // register writes: 0 train_mode, 1 epsilon, 2 momentum
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [16:0]       cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: sweep, request dispatch, statistics close and result hand-off
  bnce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // channel store, accumulator, shared multiplier, divide/isqrt unit, output register
  bnce_dp #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .s_tlast_i  (s_axis_tlast),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

### design/bnce_ram.sv
module bnce_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/bnce_arith.sv
module bnce_arith
  import bnce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        inv_mode_i,
  input  logic [63:0] dividend_i,
  input  logic [32:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o,
  output logic [23:0] inv_o
);

  typedef enum logic [3:0] {
    AS_IDLE = 4'b0001,
    AS_DIV  = 4'b0010,
    AS_SQRT = 4'b0100,
    AS_DONE = 4'b1000
  } ar_state_e;

  ar_state_e   state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        inv_mode_q;
  logic [32:0] div_q, rem_q;
  logic [63:0] quot_q;
  logic [48:0] n_q, bit_q;
  logic [49:0] root_q;
  logic [23:0] inv_q;

  logic [33:0] rem_sh;
  logic        div_ge;
  logic [32:0] rem_nx;
  logic [49:0] sq_sum;
  logic        sq_ge;
  logic [49:0] root_nx;

  assign rem_sh  = {rem_q, quot_q[63]};
  assign div_ge  = rem_sh >= {1'b0, div_q};
  assign rem_nx  = div_ge ? 33'(rem_sh - {1'b0, div_q}) : rem_sh[32:0];
  assign sq_sum  = root_q + {1'b0, bit_q};
  assign sq_ge   = {1'b0, n_q} >= sq_sum;
  assign root_nx = sq_ge ? ((root_q >> 1) + {1'b0, bit_q}) : (root_q >> 1);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      AS_IDLE: begin
        if (start_i) begin
          cnt_d   = 6'd63;
          state_d = (inv_mode_i && divisor_i == 33'd0) ? AS_DONE : AS_DIV;
        end
      end
      AS_DIV: begin
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          cnt_d   = 6'd24;
          state_d = inv_mode_q ? AS_SQRT : AS_DONE;
        end
      end
      AS_SQRT: begin
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) state_d = AS_DONE;
      end
      AS_DONE: state_d = AS_IDLE;
      default: state_d = AS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AS_IDLE;
      cnt_q   <= 6'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == AS_IDLE && start_i) begin
      inv_mode_q <= inv_mode_i;
      div_q      <= divisor_i;
      rem_q      <= 33'd0;
      quot_q     <= dividend_i;
      inv_q      <= INV_SAT;
    end else if (state_q == AS_DIV) begin
      rem_q  <= rem_nx;
      quot_q <= {quot_q[62:0], div_ge};
      if (cnt_q == 6'd0) begin
        n_q    <= {quot_q[47:0], div_ge};
        root_q <= 50'd0;
        bit_q  <= 49'h1_0000_0000_0000;
      end
    end else if (state_q == AS_SQRT) begin
      if (sq_ge) n_q <= n_q - sq_sum[48:0];
      root_q <= root_nx;
      bit_q  <= bit_q >> 2;
      if (cnt_q == 6'd0) inv_q <= (root_nx > 50'hFFFFFF) ? INV_SAT : root_nx[23:0];
    end
  end

  assign done_o = state_q == AS_DONE;
  assign quot_o = quot_q;
  assign inv_o  = inv_q;

endmodule

### design/bnce_ctrl.sv
module bnce_ctrl
  import bnce_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [21:0] {
    ST_SW_RD   = 22'h000001,
    ST_SW_INV  = 22'h000002,
    ST_SW_WAIT = 22'h000004,
    ST_IDLE    = 22'h000008,
    ST_DISP    = 22'h000010,
    ST_P0_WAIT = 22'h000020,
    ST_ACC     = 22'h000040,
    ST_DIV_GO  = 22'h000080,
    ST_DIV_WT  = 22'h000100,
    ST_M1      = 22'h000200,
    ST_M2      = 22'h000400,
    ST_M3      = 22'h000800,
    ST_M4      = 22'h001000,
    ST_M5      = 22'h002000,
    ST_IB_WAIT = 22'h004000,
    ST_IR_GO   = 22'h008000,
    ST_IR_WAIT = 22'h010000,
    ST_N1      = 22'h020000,
    ST_N2      = 22'h040000,
    ST_N3      = 22'h080000,
    ST_EMIT    = 22'h100000,
    ST_SPARE   = 22'h200000
  } st_e;

  st_e  state_q, state_d;
  logic init_q, init_d;
  logic eps_pend_q, eps_pend_d;
  logic pass_ok;

  assign pass_ok = stat_i.in_ch_ok &&
                   !((stat_i.in_func == FN_MEAN || stat_i.in_func == FN_VAR) && !stat_i.train);

  always_comb begin
    state_d    = state_q;
    init_d     = init_q;
    eps_pend_d = eps_pend_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cmd_o.sweep_init = init_q;
    // epsilon written while busy, sweep again once idle
    if (stat_i.eps_wr && state_q != ST_IDLE) eps_pend_d = 1'b1;
    unique case (state_q)
      ST_SW_RD: begin
        cmd_o.ram_rd    = 1'b1;
        cmd_o.use_sweep = 1'b1;
        state_d = ST_SW_INV;
      end
      ST_SW_INV: begin
        cmd_o.arith_start = 1'b1;
        cmd_o.arith_op    = AR_INV_SWEEP;
        cmd_o.use_sweep   = 1'b1;
        state_d = ST_SW_WAIT;
      end
      ST_SW_WAIT: begin
        cmd_o.use_sweep = 1'b1;
        cmd_o.arith_op  = AR_INV_SWEEP;
        if (stat_i.arith_done) begin
          cmd_o.ram_wr = 1'b1;
          cmd_o.wr_sel = WR_SWEEP;
          if (stat_i.sweep_last) begin
            cmd_o.sweep_clr = 1'b1;
            init_d  = 1'b0;
            state_d = ST_IDLE;
          end else begin
            cmd_o.sweep_inc = 1'b1;
            state_d = ST_SW_RD;
          end
        end
      end
      ST_IDLE: begin
        in_ready_o = !stat_i.eps_wr && !eps_pend_q;
        if (stat_i.eps_wr || eps_pend_q) begin
          eps_pend_d = 1'b0;
          state_d    = ST_SW_RD;
        end else if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          if (pass_ok) begin
            cmd_o.ram_rd = 1'b1;
            state_d = ST_DISP;
          end
        end
      end
      ST_DISP: begin
        unique case (stat_i.item_func)
          FN_PARAM: begin
            cmd_o.arith_start = 1'b1;
            cmd_o.arith_op    = AR_INV_PARAM;
            state_d = ST_P0_WAIT;
          end
          FN_MEAN, FN_VAR: begin
            cmd_o.mul_op = MUL_DEV;
            state_d = ST_ACC;
          end
          default: begin
            cmd_o.mul_op = MUL_NORM;
            state_d = ST_N1;
          end
        endcase
      end
      ST_P0_WAIT: begin
        if (stat_i.arith_done) begin
          cmd_o.ram_wr = 1'b1;
          cmd_o.wr_sel = WR_PARAM;
          state_d = ST_IDLE;
        end
      end
      ST_ACC: begin
        cmd_o.acc_step = 1'b1;
        state_d = stat_i.item_last ? ST_DIV_GO : ST_IDLE;
      end
      ST_DIV_GO: begin
        cmd_o.arith_start = 1'b1;
        cmd_o.arith_op    = (stat_i.item_func == FN_MEAN) ? AR_DIV_MEAN : AR_DIV_VAR;
        state_d = ST_DIV_WT;
      end
      ST_DIV_WT: begin
        if (stat_i.arith_done) begin
          cmd_o.acc_clr = 1'b1;
          if (stat_i.item_func == FN_MEAN) begin
            cmd_o.ram_wr = 1'b1;
            cmd_o.wr_sel = WR_MEAN;
            state_d = ST_IDLE;
          end else begin
            cmd_o.bv_fin = 1'b1;
            state_d = ST_M1;
          end
        end
      end
      ST_M1: begin
        cmd_o.mul_op = MUL_MB;
        state_d = ST_M2;
      end
      ST_M2: begin
        cmd_o.mac_load = 1'b1;
        cmd_o.mul_op   = MUL_MR;
        state_d = ST_M3;
      end
      ST_M3: begin
        cmd_o.rmean_fin = 1'b1;
        cmd_o.mul_op    = MUL_VB;
        state_d = ST_M4;
      end
      ST_M4: begin
        cmd_o.mac_load = 1'b1;
        cmd_o.mul_op   = MUL_VR;
        state_d = ST_M5;
      end
      ST_M5: begin
        cmd_o.rvar_fin    = 1'b1;
        cmd_o.arith_start = 1'b1;
        cmd_o.arith_op    = AR_INV_BATCH;
        state_d = ST_IB_WAIT;
      end
      ST_IB_WAIT: begin
        if (stat_i.arith_done) begin
          cmd_o.binv_fin = 1'b1;
          state_d = ST_IR_GO;
        end
      end
      ST_IR_GO: begin
        cmd_o.arith_start = 1'b1;
        cmd_o.arith_op    = AR_INV_RUN;
        state_d = ST_IR_WAIT;
      end
      ST_IR_WAIT: begin
        if (stat_i.arith_done) begin
          cmd_o.ram_wr = 1'b1;
          cmd_o.wr_sel = WR_STATS;
          state_d = ST_EMIT;
        end
      end
      ST_N1: begin
        cmd_o.normed_fin = 1'b1;
        state_d = ST_N2;
      end
      ST_N2: begin
        cmd_o.mul_op = MUL_SCALE;
        state_d = ST_N3;
      end
      ST_N3: begin
        cmd_o.scaled_fin = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = (stat_i.item_func == FN_NORM) ? KIND_ELEM : KIND_STATS;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_SW_RD;
      init_q     <= 1'b1;
      eps_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      init_q     <= init_d;
      eps_pend_q <= eps_pend_d;
    end
  end

`ifndef SYNTH
  a_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.ram_rd && cmd_o.ram_wr)) else $error("ram read and write together");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> stat_i.out_free) else $error("result loaded over a waiting one");
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DISP || state_q == ST_IDLE))
    else $error("bad state after request accept");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.arith_start |-> !stat_i.arith_done) else $error("arith started while finishing");
`endif

endmodule

### design/bnce_dp.sv
module bnce_dp
  import bnce_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 64,
  parameter int unsigned MAX_ELEMENTS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [16:0]       cfg_data_i,
  input  logic [IN_DW-1:0]  s_tdata_i,
  input  logic [1:0]        s_tuser_i,
  input  logic              s_tlast_i,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [OUT_DW-1:0] m_tdata_o,
  output logic              m_tuser_o
);

  localparam int unsigned ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam logic [6:0]  CH_LIMIT = (MAX_CHANNELS > 64) ? 7'd64 : 7'(MAX_CHANNELS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAX_CHANNELS - 1);

  // configuration
  logic        train_q;
  logic [15:0] eps_q;
  logic [16:0] mom_q;

  // request held for the whole item
  func_e              func_q;
  logic [5:0]         ch_q;
  logic signed [15:0] x_q, gam_q, bet_q, mn_q;
  logic [31:0]        var_q;
  logic               last_q;

  logic [ADDR_W-1:0]  sweep_q;
  logic [ACC_W-1:0]   acc_q;
  logic [CNT_W-1:0]   cnt_q;

  logic signed [PROD_W-1:0] mul_q, mac_q;
  logic signed [31:0] rmean_new_q;
  logic [31:0]        rvar_new_q, bv_q;
  logic [23:0]        binv_q;
  logic signed [15:0] normed_q, scaled_q;

  logic               out_valid_q, out_kind_q;
  logic [5:0]         out_ch_q;
  logic [15:0]        out_scaled_q, out_normed_q, out_bmean_q;
  logic [31:0]        out_bvar_q;

  row_t              row, wrow, base;
  logic [ADDR_W-1:0] raddr, waddr;

  logic        ar_done;
  logic [63:0] ar_quot, ar_dividend, qs;
  logic [32:0] ar_divisor;
  logic [23:0] ar_inv;
  logic        ar_inv_mode;
  logic [31:0] v_src;

  logic signed [MUL_W-1:0]  ma, mb, xs, mean_s, diff;
  logic [23:0]              inv_sel;
  logic signed [PROD_W-1:0] rnd_sum, norm_t, scale_t;
  logic                     out_free;

  assign raddr = cmd_i.use_sweep ? sweep_q
               : (cmd_i.latch_item ? ADDR_W'(s_tdata_i[5:0]) : ADDR_W'(ch_q));
  assign waddr = cmd_i.use_sweep ? sweep_q : ADDR_W'(ch_q);

  bnce_ram #(.WIDTH($bits(row_t)), .DEPTH(MAX_CHANNELS)) u_rows (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_wr),
    .waddr_i (waddr),
    .wdata_i (wrow),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (raddr),
    .rdata_o (row)
  );

  // operands of the shared divide and inverse square root unit
  always_comb begin
    v_src       = 32'd0;
    ar_inv_mode = 1'b1;
    unique case (cmd_i.arith_op)
      AR_INV_SWEEP: v_src = cmd_i.sweep_init ? 32'd0 : row.rvar;
      AR_INV_PARAM: v_src = var_q;
      AR_INV_BATCH: v_src = bv_q;
      AR_INV_RUN:   v_src = rvar_new_q;
      default:      ar_inv_mode = 1'b0;
    endcase
    if (ar_inv_mode) begin
      ar_dividend = 64'h0001_0000_0000_0000;
      ar_divisor  = {1'b0, v_src} + {17'd0, eps_q};
    end else begin
      ar_divisor  = {{(33-CNT_W){1'b0}}, cnt_q};
      if (cmd_i.arith_op == AR_DIV_MEAN && acc_q[ACC_W-1]) ar_dividend = 64'd0 - acc_q;
      else ar_dividend = acc_q;
    end
  end

  bnce_arith u_arith (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.arith_start),
    .inv_mode_i (ar_inv_mode),
    .dividend_i (ar_dividend),
    .divisor_i  (ar_divisor),
    .done_o     (ar_done),
    .quot_o     (ar_quot),
    .inv_o      (ar_inv)
  );

  // mean quotient carries the sign of the sum, truncated toward zero
  assign qs = acc_q[ACC_W-1] ? (64'd0 - ar_quot) : ar_quot;

  // shared multiplier operands
  assign xs      = {{(MUL_W-16){x_q[15]}}, x_q};
  assign mean_s  = train_q ? {row.bmean[31], row.bmean} : {row.rmean[31], row.rmean};
  assign inv_sel = train_q ? row.binv : row.rinv;
  assign diff    = xs - ((cmd_i.mul_op == MUL_DEV) ? {row.bmean[31], row.bmean} : mean_s);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd_i.mul_op)
      MUL_DEV:   begin ma = diff; mb = diff; end
      MUL_NORM:  begin ma = diff; mb = {9'd0, inv_sel}; end
      MUL_SCALE: begin
        ma = {{(MUL_W-16){row.scale[15]}}, row.scale};
        mb = {{(MUL_W-16){normed_q[15]}}, normed_q};
      end
      MUL_MB:    begin ma = {16'd0, mom_q}; mb = {row.bmean[31], row.bmean}; end
      MUL_MR:    begin ma = {16'd0, 17'(MOM_ONE - mom_q)}; mb = {row.rmean[31], row.rmean}; end
      MUL_VB:    begin ma = {16'd0, mom_q}; mb = {1'b0, bv_q}; end
      MUL_VR:    begin ma = {16'd0, 17'(MOM_ONE - mom_q)}; mb = {1'b0, row.rvar}; end
      default:   begin ma = '0; mb = '0; end
    endcase
  end

  assign rnd_sum = mac_q + mul_q + 66'sd32768;
  assign norm_t  = (mul_q + 66'sd32768) >>> 16;
  assign scale_t = (mul_q + ($signed({{(PROD_W-16){row.shift[15]}}, row.shift}) <<< 8)
                    + 66'sd128) >>> 8;

  // row write data
  always_comb begin
    base = cmd_i.sweep_init ? ROW_RESET : row;
    wrow = row;
    unique case (cmd_i.wr_sel)
      WR_SWEEP: begin
        wrow      = base;
        wrow.rinv = ar_inv;
      end
      WR_PARAM: begin
        wrow.scale = gam_q;
        wrow.shift = bet_q;
        wrow.rmean = {{16{mn_q[15]}}, mn_q};
        wrow.rvar  = var_q;
        wrow.rinv  = ar_inv;
      end
      WR_MEAN:  wrow.bmean = qs[31:0];
      default: begin
        wrow.rmean = rmean_new_q;
        wrow.rvar  = rvar_new_q;
        wrow.binv  = binv_q;
        wrow.rinv  = ar_inv;
      end
    endcase
  end

  assign out_free = !out_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      train_q     <= 1'b1;
      eps_q       <= 16'd1;
      mom_q       <= 17'd6554;
      sweep_q     <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_TRAIN: train_q <= cfg_data_i[0];
          REG_EPS:   eps_q   <= cfg_data_i[15:0];
          REG_MOM:   mom_q   <= (cfg_data_i > MOM_ONE) ? MOM_ONE : cfg_data_i;
          default:   ;
        endcase
      end
      if (cmd_i.sweep_clr) sweep_q <= '0;
      else if (cmd_i.sweep_inc) sweep_q <= sweep_q + ADDR_W'(1);
      if (cmd_i.acc_clr) begin
        acc_q <= '0;
        cnt_q <= '0;
      end else if (cmd_i.acc_step && cnt_q < CNT_MAX) begin
        acc_q <= acc_q + ((func_q == FN_MEAN) ? {{(ACC_W-16){x_q[15]}}, x_q}
                                              : mul_q[ACC_W-1:0]);
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (m_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      func_q <= func_e'(s_tuser_i);
      ch_q   <= s_tdata_i[5:0];
      x_q    <= s_tdata_i[21:6];
      gam_q  <= s_tdata_i[37:22];
      bet_q  <= s_tdata_i[53:38];
      mn_q   <= s_tdata_i[69:54];
      var_q  <= s_tdata_i[101:70];
      last_q <= s_tlast_i;
    end
    if (cmd_i.mul_op != MUL_NONE) mul_q <= ma * mb;
    if (cmd_i.mac_load) mac_q <= mul_q;
    if (cmd_i.rmean_fin) rmean_new_q <= rnd_sum[47:16];
    if (cmd_i.rvar_fin) rvar_new_q <= rnd_sum[47:16];
    if (cmd_i.bv_fin) bv_q <= ar_quot[31:0];
    if (cmd_i.binv_fin) binv_q <= ar_inv;
    if (cmd_i.normed_fin) normed_q <= sat16(norm_t);
    if (cmd_i.scaled_fin) scaled_q <= sat16(scale_t);
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.emit_kind;
      out_ch_q   <= ch_q;
      if (cmd_i.emit_kind == KIND_ELEM) begin
        out_scaled_q <= scaled_q;
        out_normed_q <= normed_q;
        out_bmean_q  <= 16'd0;
        out_bvar_q   <= 32'd0;
      end else begin
        out_scaled_q <= 16'd0;
        out_normed_q <= 16'd0;
        out_bmean_q  <= row.bmean[15:0];
        out_bvar_q   <= bv_q;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tdata_o  = {2'b00, out_bvar_q, out_bmean_q, out_normed_q, out_scaled_q, out_ch_q};

  assign stat_o.in_func    = func_e'(s_tuser_i);
  assign stat_o.in_ch_ok   = {1'b0, s_tdata_i[5:0]} < CH_LIMIT;
  assign stat_o.item_func  = func_q;
  assign stat_o.item_last  = last_q;
  assign stat_o.train      = train_q;
  assign stat_o.eps_wr     = cfg_we_i && cfg_idx_i == REG_EPS;
  assign stat_o.arith_done = ar_done;
  assign stat_o.sweep_last = sweep_q == ADDR_LAST;
  assign stat_o.out_free   = out_free;

endmodule
